/* rtl/core/aalg_pkg.sv */
// Shared constants, types and codes for the antialiased line generator.
`default_nettype none

package aalg_pkg;

    // Field and datapath widths
    localparam int COORD_BITS    = 12;
    localparam int PIX_BITS      = COORD_BITS + 1;
    localparam int STEP_BITS     = COORD_BITS + 1;
    localparam int ACC_BITS      = 16;
    localparam int WEIGHT_BITS   = 16;
    localparam int IBITS_W       = 5;
    localparam int CNT_BITS      = $clog2(ACC_BITS);
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PIX_BITS-1:0]   pix_t;
    typedef logic [COORD_BITS-1:0]        mag_t;
    typedef logic [STEP_BITS-1:0]         steps_t;
    typedef logic [ACC_BITS-1:0]          acc_t;
    typedef logic [WEIGHT_BITS-1:0]       weight_t;
    typedef logic [IBITS_W-1:0]           ibits_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;
    typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;

    // Operation codes of an input item
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    localparam cfg_idx_t CFG_INTENSITY  = 1'b0;
    localparam cfg_idx_t CFG_COMPLEMENT = 1'b1;

    localparam ibits_t    INTENSITY_RESET  = 5'd8;
    localparam cfg_data_t COMPLEMENT_RESET = 16'd255;

    // Line kinds
    localparam logic [2:0] KIND_HORIZ = 3'd0;
    localparam logic [2:0] KIND_VERT  = 3'd1;
    localparam logic [2:0] KIND_DIAG  = 3'd2;
    localparam logic [2:0] KIND_YMAJ  = 3'd3;
    localparam logic [2:0] KIND_XMAJ  = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic start;       // latch endpoints and classify the line
        logic div_step;    // one quotient bit of the increment
        logic load_start;  // put the first endpoint in the output register
        logic advance;     // one pixel step, main pixel to the output register
        logic load_pair;   // paired pixel to the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic active;      // a line is in progress
        logic major;       // X-major or Y-major line
        logic multi;       // more than one step left
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/aalg_dpath.sv */
// Datapath: line state, restoring divider, pixel stepping and output register.
`default_nettype none

module aalg_dpath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire aalg_pkg::dp_cmd_t     cmd,
    output aalg_pkg::dp_status_t       status,
    input  wire aalg_pkg::coord_t      start_x,
    input  wire aalg_pkg::coord_t      start_y,
    input  wire aalg_pkg::coord_t      end_x,
    input  wire aalg_pkg::coord_t      end_y,
    input  wire logic                  cfg_write,
    input  wire aalg_pkg::cfg_idx_t    cfg_index,
    input  wire aalg_pkg::cfg_data_t   cfg_data,
    output aalg_pkg::pix_t             pixel_x,
    output aalg_pkg::pix_t             pixel_y,
    output aalg_pkg::weight_t          weight,
    output logic                       last_pixel
);
    import aalg_pkg::*;

    // Weight from the top bits of the accumulator
    function automatic weight_t weight_of(input acc_t acc, input ibits_t bits);
        ibits_t eff;
        ibits_t shamt;
        eff   = (bits > IBITS_W'(ACC_BITS)) ? IBITS_W'(ACC_BITS) : bits;
        shamt = IBITS_W'(ACC_BITS) - eff;
        if (bits == '0)
            weight_of = '0;
        else
            weight_of = WEIGHT_BITS'(acc >> shamt);
    endfunction

    // Control state (reset)
    logic       active_reg, active_next;
    logic [2:0] kind_reg;
    ibits_t     intensity_reg;
    weight_t    mask_reg;

    // Line payload state
    coord_t  cur_x_reg, cur_y_reg, final_x_reg, final_y_reg;
    steps_t  steps_reg;
    acc_t    acc_reg, step_reg;
    logic    x_neg_reg;
    mag_t    rem_reg, den_reg;

    // Output and paired pixel registers
    pix_t    out_x_reg, out_y_reg, pair_x_reg, pair_y_reg;
    weight_t out_w_reg, pair_w_reg;
    logic    out_last_reg;

    // Start: order endpoints and classify
    logic              swap;
    coord_t            sx, sy, ex, ey;
    logic signed [PIX_BITS-1:0] dx_s, dy_s, adx_s;
    logic              x_neg_s;
    mag_t              adx, dy;
    logic [2:0]        kind_s;
    mag_t              steps_s, minor_s, major_s;

    always_comb
    begin
        swap    = start_y > end_y;
        sx      = swap ? end_x : start_x;
        sy      = swap ? end_y : start_y;
        ex      = swap ? start_x : end_x;
        ey      = swap ? start_y : end_y;
        dx_s    = {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
        dy_s    = {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
        x_neg_s = dx_s[PIX_BITS-1];
        adx_s   = x_neg_s ? -dx_s : dx_s;
        adx     = adx_s[COORD_BITS-1:0];
        dy      = dy_s[COORD_BITS-1:0];
        minor_s = adx;
        major_s = dy;
        if (dy == '0)
        begin
            kind_s  = KIND_HORIZ;
            steps_s = adx;
        end
        else if (adx == '0)
        begin
            kind_s  = KIND_VERT;
            steps_s = dy;
        end
        else if (adx == dy)
        begin
            kind_s  = KIND_DIAG;
            steps_s = dy;
        end
        else if (dy > adx)
        begin
            kind_s  = KIND_YMAJ;
            steps_s = dy;
        end
        else
        begin
            kind_s  = KIND_XMAJ;
            steps_s = adx;
            minor_s = dy;
            major_s = adx;
        end
    end

    // Divider: one quotient bit per cycle into the increment
    logic [COORD_BITS:0] rem_sh;
    logic                q_bit;
    mag_t                rem_next;
    acc_t                step_next;

    always_comb
    begin
        rem_sh    = {rem_reg, 1'b0};
        q_bit     = rem_sh >= {1'b0, den_reg};
        rem_next  = q_bit ? COORD_BITS'(rem_sh - {1'b0, den_reg}) : COORD_BITS'(rem_sh);
        step_next = {step_reg[ACC_BITS-2:0], q_bit};
    end

    // Pixel step
    coord_t  x_adv, cur_x_next, cur_y_next;
    steps_t  steps_next;
    acc_t    acc_sum, acc_next;
    logic    turned;
    weight_t w_main;
    pix_t    main_x, main_y, pair_x, pair_y;
    weight_t main_w;
    logic    main_last;

    always_comb
    begin
        x_adv       = x_neg_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
        acc_sum     = acc_reg + step_reg;
        turned      = acc_sum <= acc_reg;
        w_main      = weight_of(acc_sum, intensity_reg);
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        acc_next    = acc_reg;
        steps_next  = steps_reg - STEP_BITS'(1);
        active_next = active_reg;
        main_w      = '0;
        main_last   = 1'b0;
        pair_x      = '0;
        pair_y      = '0;
        if (kind_reg <= KIND_DIAG)
        begin
            if (kind_reg != KIND_VERT)
                cur_x_next = x_adv;
            if (kind_reg != KIND_HORIZ)
                cur_y_next = cur_y_reg + COORD_BITS'(1);
            active_next = steps_next != '0;
            main_last   = !active_next;
            main_x      = {cur_x_next[COORD_BITS-1], cur_x_next};
            main_y      = {cur_y_next[COORD_BITS-1], cur_y_next};
        end
        else if (steps_reg <= STEP_BITS'(1))
        begin
            // Final endpoint of a weighted line
            steps_next  = '0;
            active_next = 1'b0;
            main_last   = 1'b1;
            main_x      = {final_x_reg[COORD_BITS-1], final_x_reg};
            main_y      = {final_y_reg[COORD_BITS-1], final_y_reg};
        end
        else
        begin
            acc_next = acc_sum;
            main_w   = w_main;
            if (kind_reg == KIND_YMAJ)
            begin
                if (turned)
                    cur_x_next = x_adv;
                cur_y_next = cur_y_reg + COORD_BITS'(1);
            end
            else
            begin
                if (turned)
                    cur_y_next = cur_y_reg + COORD_BITS'(1);
                cur_x_next = x_adv;
            end
            main_x = {cur_x_next[COORD_BITS-1], cur_x_next};
            main_y = {cur_y_next[COORD_BITS-1], cur_y_next};
            if (kind_reg == KIND_YMAJ)
            begin
                pair_x = x_neg_reg ? main_x - PIX_BITS'(1) : main_x + PIX_BITS'(1);
                pair_y = main_y;
            end
            else
            begin
                pair_x = main_x;
                pair_y = main_y + PIX_BITS'(1);
            end
        end
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            kind_reg      <= KIND_HORIZ;
            intensity_reg <= INTENSITY_RESET;
            mask_reg      <= COMPLEMENT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_INTENSITY:  intensity_reg <= cfg_data[IBITS_W-1:0];
                    CFG_COMPLEMENT: mask_reg      <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.start)
            begin
                active_reg <= steps_s != '0;
                kind_reg   <= kind_s;
            end
            else if (cmd.advance)
                active_reg <= active_next;
        end
    end

    // Line payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cur_x_reg   <= sx;
            cur_y_reg   <= sy;
            final_x_reg <= ex;
            final_y_reg <= ey;
            steps_reg   <= {1'b0, steps_s};
            x_neg_reg   <= x_neg_s;
            acc_reg     <= '0;
            step_reg    <= '0;
            rem_reg     <= minor_s;
            den_reg     <= major_s;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            step_reg <= step_next;
        end
        if (cmd.advance)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            steps_reg  <= steps_next;
            acc_reg    <= acc_next;
            pair_x_reg <= pair_x;
            pair_y_reg <= pair_y;
            pair_w_reg <= main_w ^ mask_reg;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            out_x_reg    <= {cur_x_reg[COORD_BITS-1], cur_x_reg};
            out_y_reg    <= {cur_y_reg[COORD_BITS-1], cur_y_reg};
            out_w_reg    <= '0;
            out_last_reg <= !active_reg;
        end
        else if (cmd.advance)
        begin
            out_x_reg    <= main_x;
            out_y_reg    <= main_y;
            out_w_reg    <= main_w;
            out_last_reg <= main_last;
        end
        else if (cmd.load_pair)
        begin
            out_x_reg    <= pair_x_reg;
            out_y_reg    <= pair_y_reg;
            out_w_reg    <= pair_w_reg;
            out_last_reg <= 1'b0;
        end
    end

    assign status.active = active_reg;
    assign status.major  = (kind_reg == KIND_YMAJ) || (kind_reg == KIND_XMAJ);
    assign status.multi  = steps_reg > STEP_BITS'(1);

    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign weight     = out_w_reg;
    assign last_pixel = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/aalg_ctrl.sv */
// Controller: item handshake, division sequencing and result emission.
`default_nettype none

module aalg_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output aalg_pkg::dp_cmd_t          cmd,
    input  wire aalg_pkg::dp_status_t  status
);
    import aalg_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DIV        = 3'd1;
    localparam logic [2:0] S_EMIT_START = 3'd2;
    localparam logic [2:0] S_STEP       = 3'd3;
    localparam logic [2:0] S_EMIT_PAIR  = 3'd4;

    logic [2:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept, out_free, loading;

    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_START)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                    else if (status.active)
                        state_next = S_STEP;
                end
            end
            S_DIV:
            begin
                if (!status.major)
                    state_next = S_EMIT_START;
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(ACC_BITS - 1))
                        state_next = S_EMIT_START;
                end
            end
            S_EMIT_START:
            begin
                if (out_free)
                begin
                    cmd.load_start = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (out_free)
                begin
                    cmd.advance = 1'b1;
                    state_next  = (status.major && status.multi) ? S_EMIT_PAIR : S_IDLE;
                end
            end
            S_EMIT_PAIR:
            begin
                if (out_free)
                begin
                    cmd.load_pair = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid flag
    assign loading = cmd.load_start || cmd.advance || cmd.load_pair;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (loading)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // A start item always goes through the division state
    a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_START) |=> state_reg == S_DIV)
        else $error("start item did not enter division");

    // A step with no line in progress gives no item
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == OP_STEP) && !status.active |=> state_reg == S_IDLE)
        else $error("step without a line left idle");

    // The paired pixel follows only a pixel step
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT_PAIR |->
            ($past(state_reg) == S_STEP) || ($past(state_reg) == S_EMIT_PAIR))
        else $error("paired pixel without a main pixel");

    // Output valid rises only when a result is loaded
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(loading))
        else $error("output valid without a load");
`endif

endmodule

`default_nettype wire

/* rtl/core/antialiased_line_generator_unit.sv */
// Top level of the antialiased line generator: controller plus datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   operation, start_x, start_y, end_x, end_y
//   out      output     out_valid/out_stall pixel_x, pixel_y, weight, last_pixel
//   cfg      input      cfg_write           cfg_index, cfg_data
//
// Start item: the endpoints are latched and classified; for X-major and Y-major lines
// the restoring divider (one quotient bit a cycle) then forms the increment, and the
// first endpoint is loaded. Step item: the main pixel is loaded, then the paired pixel
// when one follows; no pixel without a line in progress. One output register is shared.
// Reset is asynchronous: no line in progress, intensity_bits 8, complement_mask 255.
// in_stall is high whenever an item is in work; out_stall holds the pending emit.
`default_nettype none

module antialiased_line_generator_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire aalg_pkg::coord_t     start_x,
    input  wire aalg_pkg::coord_t     start_y,
    input  wire aalg_pkg::coord_t     end_x,
    input  wire aalg_pkg::coord_t     end_y,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output aalg_pkg::pix_t            pixel_x,
    output aalg_pkg::pix_t            pixel_y,
    output aalg_pkg::weight_t         weight,
    output logic                      last_pixel,
    input  wire logic                 cfg_write,
    input  wire aalg_pkg::cfg_idx_t   cfg_index,
    input  wire aalg_pkg::cfg_data_t  cfg_data
);
    import aalg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    aalg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    aalg_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .weight     (weight),
        .last_pixel (last_pixel)
    );

endmodule

`default_nettype wire

/* tb/aalg_pixel_checker.sv */
// Pixel stream checker for the antialiased line generator: predicts and compares every pixel.
module aalg_pixel_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                operation,
    input  aalg_pkg::coord_t    start_x,
    input  aalg_pkg::coord_t    start_y,
    input  aalg_pkg::coord_t    end_x,
    input  aalg_pkg::coord_t    end_y,
    input  logic                out_valid,
    input  logic                out_stall,
    input  aalg_pkg::pix_t      pixel_x,
    input  aalg_pkg::pix_t      pixel_y,
    input  aalg_pkg::weight_t   weight,
    input  logic                last_pixel,
    input  logic                cfg_write,
    input  aalg_pkg::cfg_idx_t  cfg_index,
    input  aalg_pkg::cfg_data_t cfg_data,
    output int                  pixel_errors,
    output int                  pixels_due,
    output int                  pixels_checked
);
    import aalg_pkg::*;

    typedef struct packed {
        pix_t    x;
        pix_t    y;
        weight_t w;
        logic    last;
    } pixel_t;

    pixel_t pixel_q[$];

    // Register copies
    ibits_t  ibits;
    weight_t cmask;

    // Line walker state
    int         cur_x, cur_y, fin_x, fin_y, steps_left;
    acc_t       err_acc, err_inc;
    bit         x_neg, line_on;
    logic [2:0] kind;

    int err_count, seen;

    // Weight from the top bits of the accumulator
    function automatic weight_t weight_of(acc_t a);
        int nbits;
        nbits = ibits;
        if (nbits == 0)
            return '0;
        if (nbits > ACC_BITS)
            nbits = ACC_BITS;
        return weight_t'(a >> (ACC_BITS - nbits));
    endfunction

    task automatic queue_pixel(int x, int y, weight_t w, logic last);
        pixel_t p;
        p.x    = pix_t'(x);
        p.y    = pix_t'(y);
        p.w    = w;
        p.last = last;
        pixel_q = {pixel_q, p};
    endtask

    // Start item: order endpoints top to bottom, classify, emit the first pixel
    task automatic plot_start(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        int ax, ay, bx, by, dx, dy;
        ax = sx;
        ay = sy;
        bx = ex;
        by = ey;
        if (ay > by)
        begin
            ax = ex;
            ay = ey;
            bx = sx;
            by = sy;
        end
        cur_x = ax;
        cur_y = ay;
        fin_x = bx;
        fin_y = by;
        dx = bx - ax;
        x_neg = dx < 0;
        if (x_neg)
            dx = -dx;
        dy = by - ay;
        err_acc = '0;
        err_inc = '0;
        if (dy == 0)
        begin
            kind = KIND_HORIZ;
            steps_left = dx;
        end
        else if (dx == 0)
        begin
            kind = KIND_VERT;
            steps_left = dy;
        end
        else if (dx == dy)
        begin
            kind = KIND_DIAG;
            steps_left = dy;
        end
        else if (dy > dx)
        begin
            kind = KIND_YMAJ;
            steps_left = dy;
            err_inc = acc_t'((longint'(dx) << ACC_BITS) / longint'(dy));
        end
        else
        begin
            kind = KIND_XMAJ;
            steps_left = dx;
            err_inc = acc_t'((longint'(dy) << ACC_BITS) / longint'(dx));
        end
        line_on = steps_left != 0;
        queue_pixel(cur_x, cur_y, '0, !line_on);
    endtask

    // Step item: next pixel, or main plus paired pixel on a weighted line
    task automatic plot_step();
        int      xdir;
        acc_t    prev;
        weight_t w;
        bit      turned;
        if (!line_on)
            return;
        xdir = x_neg ? -1 : 1;
        if (kind == KIND_HORIZ || kind == KIND_VERT || kind == KIND_DIAG)
        begin
            if (kind != KIND_VERT)
                cur_x += xdir;
            if (kind != KIND_HORIZ)
                cur_y += 1;
            steps_left--;
            line_on = steps_left != 0;
            queue_pixel(cur_x, cur_y, '0, !line_on);
        end
        else if (steps_left <= 1)
        begin
            // closing endpoint, unweighted
            steps_left = 0;
            line_on = 1'b0;
            queue_pixel(fin_x, fin_y, '0, 1'b1);
        end
        else
        begin
            prev = err_acc;
            err_acc = err_acc + err_inc;
            turned = err_acc <= prev;
            w = weight_of(err_acc);
            if (kind == KIND_YMAJ)
            begin
                if (turned)
                    cur_x += xdir;
                cur_y += 1;
                queue_pixel(cur_x, cur_y, w, 1'b0);
                queue_pixel(cur_x + xdir, cur_y, w ^ cmask, 1'b0);
            end
            else
            begin
                if (turned)
                    cur_y += 1;
                cur_x += xdir;
                queue_pixel(cur_x, cur_y, w, 1'b0);
                queue_pixel(cur_x, cur_y + 1, w ^ cmask, 1'b0);
            end
            steps_left--;
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        seen++;
        if (pixel_q.size() == 0)
        begin
            err_count++;
            if (err_count <= 10)
                $display("pixel %0d unexpected: x=%0d y=%0d w=%0d last=%0b",
                         seen, pixel_x, pixel_y, weight, last_pixel);
            return;
        end
        want = pixel_q.pop_front();
        if (pixel_x !== want.x || pixel_y !== want.y || weight !== want.w ||
            last_pixel !== want.last)
        begin
            err_count++;
            if (err_count <= 10)
                $display(
                    "pixel %0d: expected %0d,%0d w=%0d last=%0b, got %0d,%0d w=%0d last=%0b",
                    seen, $signed(want.x), $signed(want.y), want.w, want.last,
                    pixel_x, pixel_y, weight, last_pixel);
        end
    endtask

    // Registers, accepted items and accepted pixels, all sampled at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ibits = INTENSITY_RESET;
            cmask = COMPLEMENT_RESET;
            cur_x = 0;
            cur_y = 0;
            fin_x = 0;
            fin_y = 0;
            steps_left = 0;
            err_acc = '0;
            err_inc = '0;
            x_neg = 1'b0;
            line_on = 1'b0;
            kind = KIND_HORIZ;
            err_count = 0;
            seen = 0;
            pixel_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_INTENSITY)
                    ibits = ibits_t'(cfg_data);
                else if (cfg_index == CFG_COMPLEMENT)
                    cmask = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                if (operation == OP_START)
                    plot_start(start_x, start_y, end_x, end_y);
                else
                    plot_step();
            end
            if (out_valid && !out_stall)
                check_pixel();
        end
        pixel_errors   <= err_count;
        pixels_due     <= pixel_q.size();
        pixels_checked <= seen;
    end

endmodule

/* tb/tb.sv */
// Testbench top for the antialiased line generator: clock, reset, stimulus and verdict.
module tb;
    import aalg_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 25;
    localparam int PHASE_ITEMS = 180;

    logic      clk, rst_n;
    logic      in_valid, in_stall, operation;
    coord_t    start_x, start_y, end_x, end_y;
    logic      out_valid, out_stall;
    pix_t      pixel_x, pixel_y;
    weight_t   weight;
    logic      last_pixel;
    logic      cfg_write;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    int pixel_errors, pixels_due, pixels_checked;
    int send_gap, recv_gap, hold_left;
    int items_sent, lines_started, settings_used;
    int cycles = 0;

    antialiased_line_generator_unit dut (.*);

    aalg_pixel_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold counted down here
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_gap);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still owed", cycles, pixels_due);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int rand_coord();
        if ($urandom_range(4) == 0)
        begin
            case ($urandom_range(3))
                0: return -2048;
                1: return -2047;
                2: return 2046;
                default: return 2047;
            endcase
        end
        return int'($urandom_range(4095)) - 2048;
    endfunction

    // Move by d, or the other way when that would leave the coordinate range
    function automatic int offset(int base, int d);
        if (base + d > 2047 || base + d < -2048)
            return base - d;
        return base + d;
    endfunction

    function automatic int line_len(int dx, int dy);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        return (dx > dy) ? dx : dy;
    endfunction

    // One item through the valid/stall handshake, with random gaps before it
    task automatic send_item(logic op, int sx, int sy, int ex, int ey);
        while ($urandom_range(99) < send_gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        start_x   <= coord_t'(sx);
        start_y   <= coord_t'(sy);
        end_x     <= coord_t'(ex);
        end_y     <= coord_t'(ey);
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Start a line, then request a number of pixel steps (junk in the ignored fields)
    task automatic line_walk(int sx, int sy, int ex, int ey, int walk);
        send_item(OP_START, sx, sy, ex, ey);
        lines_started++;
        repeat (walk)
            send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    // Stop offering, wait for every owed pixel, then let a trailing step finish
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels_due != 0)
            @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Mostly short lines walked to the end, some overrun or cut short, a few long ones
    task automatic random_line();
        int sx, sy, ex, ey, dx, dy, len, walk, r;
        sx = rand_coord();
        sy = rand_coord();
        r = $urandom_range(99);
        if (r < 12)
        begin
            ex = rand_coord();
            ey = rand_coord();
            walk = $urandom_range(5);
        end
        else
        begin
            dx = $urandom_range(14);
            dy = $urandom_range(14);
            case ($urandom_range(4))
                0: dy = 0;
                1: dx = 0;
                2: dy = dx;
                default: ;
            endcase
            if ($urandom_range(1))
                dx = -dx;
            if ($urandom_range(1))
                dy = -dy;
            ex = offset(sx, dx);
            ey = offset(sy, dy);
            len = line_len(ex - sx, ey - sy);
            r = $urandom_range(99);
            if (r < 10)
                walk = $urandom_range(len);
            else if (r < 25)
                walk = len + $urandom_range(1, 2);
            else
                walk = len;
        end
        line_walk(sx, sy, ex, ey, walk);
    endtask

    task automatic run_phase(int ib, int cm, int sgap, int rgap, bit do_hold, bit do_pause);
        int stop, mid;
        bit mid_done;
        wait_drain();
        write_reg(CFG_INTENSITY, cfg_data_t'(ib));
        write_reg(CFG_COMPLEMENT, cfg_data_t'(cm));
        settings_used++;
        send_gap = sgap;
        recv_gap = rgap;
        stop = items_sent + PHASE_ITEMS;
        mid = items_sent + PHASE_ITEMS / 2;
        mid_done = 1'b0;
        while (items_sent < stop)
        begin
            if (!mid_done && items_sent >= mid)
            begin
                mid_done = 1'b1;
                if (do_hold)
                    hold_left = HOLD_CYCLES;
                if (do_pause)
                    wait_drain();
            end
            if ($urandom_range(99) < 88)
                random_line();
            else if ($urandom_range(1))
                send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
            else
            begin
                send_item(OP_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
                lines_started++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        operation = OP_START;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_INTENSITY;
        cfg_data  = '0;
        hold_left = 0;
        send_gap  = 15;
        recv_gap  = 70;
        items_sent    = 0;
        lines_started = 0;
        settings_used = 1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed lines at reset settings
        send_item(OP_STEP, -2048, 2047, 0, -1);      // step with nothing in progress
        line_walk(5, 5, 5, 5, 0);                    // zero-length line
        line_walk(2047, 2047, 2044, 2047, 4);        // horizontal leftward, then a spare step
        line_walk(0, 2047, 0, 2045, 2);              // vertical, endpoints swapped
        line_walk(-2046, -2048, -2048, -2046, 2);    // diagonal leftward
        line_walk(2045, 2044, 2047, 2047, 3);        // Y-major at right edge, minor turnover
        line_walk(-2048, 2045, -2043, 2047, 5);      // X-major at bottom edge
        line_walk(-2048, -2048, 2047, 2046, 2);      // longest X-major, abandoned by next start
        line_walk(-2048, -2048, 2046, 2047, 2);      // longest Y-major, abandoned

        // Random phases over register settings and idle patterns
        run_phase(8, 255, 15, 70, 1'b1, 1'b0);
        run_phase(16, 65535, 15, 70, 1'b0, 1'b0);
        run_phase(0, 0, 70, 15, 1'b0, 1'b1);
        run_phase(31, $urandom_range(65535), 70, 15, 1'b0, 1'b0);
        run_phase(1, 1, 0, 0, 1'b1, 1'b0);
        run_phase($urandom_range(2, 15), $urandom_range(65535), 0, 0, 1'b0, 1'b0);
        wait_drain();

        $display("Run covered %0d items (%0d line starts) and %0d checked pixels",
                 items_sent, lines_started, pixels_checked);
        $display("across %0d register settings, three idle patterns, a long hold and a drain",
                 settings_used);
        if (pixel_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* antialiased_line_generator_unit.f */
rtl/core/aalg_pkg.sv
rtl/core/aalg_dpath.sv
rtl/core/aalg_ctrl.sv
rtl/core/antialiased_line_generator_unit.sv
tb/aalg_pixel_checker.sv
tb/tb.sv
